// ----- rtl/m3_pkg.sv -----
// ----------------------------------------------------------------------------
// m3_pkg
// Shared constants, types and helpers for the MurmurHash3 x64_128 stream
// hasher: mixing constants, rotate helper, and the structs that travel
// between the sequencer, the byte gather unit and the shared multiplier.
// ----------------------------------------------------------------------------
package m3_pkg;

	// Body round constants
	localparam logic [63:0] MIX_C1 = 64'h87c3_7b91_1142_53d5;
	localparam logic [63:0] MIX_C2 = 64'h4cf5_ad43_2745_937f;

	// Final avalanche constants
	localparam logic [63:0] FMIX_K1 = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] FMIX_K2 = 64'hc4ce_b9fe_1a85_ec53;

	// Lane offsets added after the multiply by five
	localparam logic [63:0] LANE_ADD_ONE = 64'h0000_0000_52dc_e729;
	localparam logic [63:0] LANE_ADD_TWO = 64'h0000_0000_3849_5ab5;

	// Rotate and shift amounts
	localparam int unsigned ROT_K1      = 31;
	localparam int unsigned ROT_K2      = 33;
	localparam int unsigned ROT_H1      = 27;
	localparam int unsigned ROT_H2      = 31;
	localparam int unsigned FMIX_SHIFT  = 33;

	// Request to the shared 64x64 (low half) multiplier
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	// Response from the shared multiplier
	typedef struct packed {
		logic        done;
		logic [63:0] p;
	} mul_rsp_t;

	// Control into the byte gather unit
	typedef struct packed {
		logic       wr_en;
		logic [7:0] wr_byte;
		logic       clear;
		logic       tail;
	} gth_ctrl_t;

	// Status out of the byte gather unit
	typedef struct packed {
		logic [63:0] word0;
		logic [63:0] word1;
		logic [3:0]  fill;
		logic [63:0] length;
	} gth_stat_t;

	// 64-bit rotate left by a constant amount
	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
		return (v << r) | (v >> (64 - r));
	endfunction

endpackage

// ----- rtl/murmur3_x64_128_stream.sv -----
// ----------------------------------------------------------------------------
// murmur3_x64_128_stream
// MurmurHash3 x64_128 (seed zero) over a byte stream, one shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one message byte in s_axis_tdata with s_axis_tuser
//   low, or a finish command with s_axis_tuser high (tdata ignored).
//   The finish beat produces one output beat holding the 128-bit digest,
//   hash_low in m_axis_tdata[63:0] and hash_high in [127:64]. A byte beat
//   is taken while the core is idle; after the 16th byte of a block the
//   core is busy mixing it and s_axis_tready is low. A finish beat keeps
//   it busy through the tail, length and avalanche steps until the digest
//   is in the output register. Every 64-bit multiply runs through the
//   single 32x32 multiplier in three partial products; a block takes four
//   multiplies, a finish four for the tail and four for the avalanche.
//   After a finish the lanes and gather counters return to zero for the
//   next message. Reset (arst_n low) clears control, lanes, counters and
//   the output register and drops m_axis_tvalid. The digest sits in an
//   output register until taken; new bytes are accepted meanwhile, and a
//   second finish waits at its last step until that register is free.
// ----------------------------------------------------------------------------
module murmur3_x64_128_stream (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tuser,   // [0] action
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // [63:0] hash_low, [127:64] hash_high
);
	import m3_pkg::*;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;
	localparam logic MODE_BLK   = 1'b0;
	localparam logic MODE_FIN   = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_M1, S_M2, S_H1, S_H1B, S_M3, S_M4, S_H2, S_H2B,
		S_LEN, S_ADD1, S_ADD2, S_AV0, S_AV1, S_AV2, S_ADD3, S_ADD4, S_OUT
	} state_t;

	state_t       state_q;
	logic         mode_q;
	logic         sel_q;
	logic         issued_q;
	logic [63:0]  h1_q;
	logic [63:0]  h2_q;
	logic [63:0]  x_q;
	logic         m_tvalid_q;
	logic [127:0] m_tdata_q;

	mul_req_t     mreq;
	mul_rsp_t     mrsp;
	gth_ctrl_t    gctl;
	gth_stat_t    gst;

	logic         in_fire;
	logic         out_free;
	logic         mul_state;
	logic [63:0]  hsel;
	logic [63:0]  pmix;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign hsel     = sel_q ? h2_q : h1_q;
	assign pmix     = mrsp.p ^ (mrsp.p >> FMIX_SHIFT);

	// Multiplier operand select
	always_comb begin
		mul_state = 1'b1;
		case (state_q)
			S_M1: begin
				mreq.a = gst.word0;
				mreq.b = MIX_C1;
			end
			S_M2: begin
				mreq.a = rotl64(x_q, ROT_K1);
				mreq.b = MIX_C2;
			end
			S_M3: begin
				mreq.a = gst.word1;
				mreq.b = MIX_C2;
			end
			S_M4: begin
				mreq.a = rotl64(x_q, ROT_K2);
				mreq.b = MIX_C1;
			end
			S_AV1: begin
				mreq.a = x_q;
				mreq.b = FMIX_K1;
			end
			S_AV2: begin
				mreq.a = x_q;
				mreq.b = FMIX_K2;
			end
			default: begin
				mul_state = 1'b0;
				mreq.a    = x_q;
				mreq.b    = '0;
			end
		endcase
		mreq.start = mul_state && !issued_q;
	end

	// Gather control
	assign gctl.wr_en   = in_fire && (s_axis_tuser == ACT_ABSORB);
	assign gctl.wr_byte = s_axis_tdata;
	assign gctl.clear   = (state_q == S_OUT) && out_free;
	assign gctl.tail    = (mode_q == MODE_FIN);

	m3_gather u_gather (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (gctl),
		.stat   (gst)
	);

	m3_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// Sequencer, lanes and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_BLK;
			sel_q      <= 1'b0;
			issued_q   <= 1'b0;
			h1_q       <= '0;
			h2_q       <= '0;
			x_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (mreq.start) begin
				issued_q <= 1'b1;
			end else if (mrsp.done) begin
				issued_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser == ACT_FINISH) begin
							mode_q  <= MODE_FIN;
							state_q <= S_M1;
						end else if (gst.fill == 4'd15) begin
							mode_q  <= MODE_BLK;
							state_q <= S_M1;
						end
					end
				end
				S_M1: begin
					if (mrsp.done) begin
						x_q     <= mrsp.p;
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (mrsp.done) begin
						x_q     <= mrsp.p;
						state_q <= S_H1;
					end
				end
				S_H1: begin
					if (mode_q == MODE_BLK) begin
						h1_q    <= rotl64(h1_q ^ x_q, ROT_H1) + h2_q;
						state_q <= S_H1B;
					end else begin
						h1_q    <= h1_q ^ x_q;
						state_q <= S_M3;
					end
				end
				S_H1B: begin
					h1_q    <= h1_q + {h1_q[61:0], 2'b00} + LANE_ADD_ONE;
					state_q <= S_M3;
				end
				S_M3: begin
					if (mrsp.done) begin
						x_q     <= mrsp.p;
						state_q <= S_M4;
					end
				end
				S_M4: begin
					if (mrsp.done) begin
						x_q     <= mrsp.p;
						state_q <= S_H2;
					end
				end
				S_H2: begin
					if (mode_q == MODE_BLK) begin
						h2_q    <= rotl64(h2_q ^ x_q, ROT_H2) + h1_q;
						state_q <= S_H2B;
					end else begin
						h2_q    <= h2_q ^ x_q;
						state_q <= S_LEN;
					end
				end
				S_H2B: begin
					h2_q    <= h2_q + {h2_q[61:0], 2'b00} + LANE_ADD_TWO;
					state_q <= S_IDLE;
				end
				S_LEN: begin
					h1_q    <= h1_q ^ gst.length;
					h2_q    <= h2_q ^ gst.length;
					state_q <= S_ADD1;
				end
				S_ADD1: begin
					h1_q    <= h1_q + h2_q;
					state_q <= S_ADD2;
				end
				S_ADD2: begin
					h2_q    <= h2_q + h1_q;
					sel_q   <= 1'b0;
					state_q <= S_AV0;
				end
				// Avalanche, lane one then lane two
				S_AV0: begin
					x_q     <= hsel ^ (hsel >> FMIX_SHIFT);
					state_q <= S_AV1;
				end
				S_AV1: begin
					if (mrsp.done) begin
						x_q     <= pmix;
						state_q <= S_AV2;
					end
				end
				S_AV2: begin
					if (mrsp.done) begin
						if (!sel_q) begin
							h1_q    <= pmix;
							sel_q   <= 1'b1;
							state_q <= S_AV0;
						end else begin
							h2_q    <= pmix;
							state_q <= S_ADD3;
						end
					end
				end
				S_ADD3: begin
					h1_q    <= h1_q + h2_q;
					state_q <= S_ADD4;
				end
				S_ADD4: begin
					h2_q    <= h2_q + h1_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_tdata_q  <= {h2_q, h1_q};
						m_tvalid_q <= 1'b1;
						h1_q       <= '0;
						h2_q       <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// A multiplier result only comes back to a request that was issued
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> issued_q)
		else $error("multiplier result without a pending request");

	// A finish beat starts the tail scramble in finish mode
	a_finish_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (s_axis_tuser == ACT_FINISH) |=> (state_q == S_M1) && (mode_q == MODE_FIN))
		else $error("finish beat did not start the tail sequence");

	// Emitting the digest leaves gather counters and lane one cleared and the digest valid
	a_clear_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_free |=>
			(gst.fill == 4'd0) && (gst.length == 64'd0) && (h1_q == 64'd0) && m_tvalid_q)
		else $error("state not cleared after digest");

endmodule

// ----- rtl/m3_mul.sv -----
// ----------------------------------------------------------------------------
// m3_mul
// Shared multiplier: low 64 bits of a 64x64 product, built from three
// 32x32 partial products through one registered 32x32 multiplier.
// ----------------------------------------------------------------------------
module m3_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  m3_pkg::mul_req_t  req,
	output m3_pkg::mul_rsp_t  rsp
);
	import m3_pkg::*;

	// Partial product phases
	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic        run_q;
	logic [1:0]  cnt_q;
	logic [63:0] prod_s1;
	logic [1:0]  ph_s1;
	logic        pv_s1;
	logic [63:0] acc_q;
	logic        done_q;

	logic [31:0] opa;
	logic [31:0] opb;
	logic [63:0] prod_c;
	logic [63:0] addend;

	// Operand select per phase
	always_comb begin
		case (cnt_q)
			PH_LL: begin
				opa = a_q[31:0];
				opb = b_q[31:0];
			end
			PH_LH: begin
				opa = a_q[31:0];
				opb = b_q[63:32];
			end
			PH_HL: begin
				opa = a_q[63:32];
				opb = b_q[31:0];
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod_c = opa * opb;

	// Cross terms land in the upper half only
	assign addend = (ph_s1 == PH_LL) ? prod_s1 : {prod_s1[31:0], 32'h0};

	// Phase sequencing, product stage valid and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= PH_LL;
			pv_s1  <= 1'b0;
			ph_s1  <= PH_LL;
			done_q <= 1'b0;
		end else begin
			pv_s1  <= run_q;
			ph_s1  <= cnt_q;
			done_q <= pv_s1 && (ph_s1 == PH_HL);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= PH_LL;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == PH_HL) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + addend;
		end
		prod_s1 <= prod_c;
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

	// A new request never lands on a product still in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !(run_q || pv_s1))
		else $error("multiplier started while busy");

	// Done is raised in the cycle after the last partial product
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 && (ph_s1 == PH_HL) |=> done_q)
		else $error("multiplier done missing after last partial product");

endmodule

// ----- rtl/m3_gather.sv -----
// ----------------------------------------------------------------------------
// m3_gather
// Byte gather: collects message bytes into a 16-byte block, counts the
// fill and the total message length, and presents the block as two
// little-endian words, masked to the filled bytes for the tail.
// ----------------------------------------------------------------------------
module m3_gather (
	input  logic               clk,
	input  logic               arst_n,
	input  m3_pkg::gth_ctrl_t  ctrl,
	output m3_pkg::gth_stat_t  stat
);
	import m3_pkg::*;

	logic [7:0]   bytes_q [16];
	logic [3:0]   fill_q;
	logic [63:0]  length_q;
	logic [127:0] block_c;

	// Byte store, written at the fill position
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			bytes_q[fill_q] <= ctrl.wr_byte;
		end
	end

	// Fill count and message length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			length_q <= '0;
		end else if (ctrl.clear) begin
			fill_q   <= '0;
			length_q <= '0;
		end else if (ctrl.wr_en) begin
			fill_q   <= fill_q + 4'd1;
			length_q <= length_q + 64'd1;
		end
	end

	// Tail bytes past the fill read as zero
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (!ctrl.tail || (4'(i) < fill_q)) begin
				block_c[i*8 +: 8] = bytes_q[i];
			end else begin
				block_c[i*8 +: 8] = 8'h00;
			end
		end
	end

	assign stat.word0  = block_c[63:0];
	assign stat.word1  = block_c[127:64];
	assign stat.fill   = fill_q;
	assign stat.length = length_q;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for murmur3_x64_128_stream. Messages of random length
// (block boundaries and tails favored) go in one byte per beat, each closed
// by a finish beat. A local model of the hasher predicts every digest, and
// the monitor compares each output beat lane by lane. Sender and receiver
// idle at random, and the receiver holds off once for a long stretch so
// the core backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Beat kinds carried on tuser
	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// Hash constants
	localparam logic [63:0] BODY_C1  = 64'h87c37b91114253d5;
	localparam logic [63:0] BODY_C2  = 64'h4cf5ad432745937f;
	localparam logic [63:0] AVAL_K1  = 64'hff51afd7ed558ccd;
	localparam logic [63:0] AVAL_K2  = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] LANE_A_ADD = 64'h0000_0000_52dc_e729;
	localparam logic [63:0] LANE_B_ADD = 64'h0000_0000_3849_5ab5;

	localparam int unsigned PHASE_BEATS  = 570;
	localparam int unsigned HOLD_AT      = 1600;
	localparam int unsigned HOLD_LEN     = 400;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam longint      TIMEOUT_NS   = 5_000_000;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} hash_beat_t;

	typedef struct packed {
		logic [63:0] hash_high;
		logic [63:0] hash_low;
	} digest_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic         s_axis_tuser = 1'b0;    // [0] action
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;           // [63:0] hash_low, [127:64] hash_high

	hash_beat_t  beat_q[$];
	digest_t     digest_q[$];
	hash_beat_t  next_beat;
	digest_t     want;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned beats_in = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned errors = 0;

	// Local copy of the hasher state
	logic [63:0] lane_a = '0;
	logic [63:0] lane_b = '0;
	logic [7:0]  blk [16];
	logic [3:0]  fill = '0;
	logic [63:0] msg_len = '0;

	murmur3_x64_128_stream uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Digest prediction
	// ------------------------------------------------------------------
	function automatic logic [63:0] rot64(input logic [63:0] v, input int unsigned r);
		logic [127:0] t;
		t = {v, v} << r;
		return t[127:64];
	endfunction

	function automatic logic [63:0] scr_a(input logic [63:0] k);
		return rot64(k * BODY_C1, 31) * BODY_C2;
	endfunction

	function automatic logic [63:0] scr_b(input logic [63:0] k);
		return rot64(k * BODY_C2, 33) * BODY_C1;
	endfunction

	function automatic logic [63:0] fold64(input logic [63:0] k);
		k = k ^ (k >> 33);
		k = k * AVAL_K1;
		k = k ^ (k >> 33);
		k = k * AVAL_K2;
		return k ^ (k >> 33);
	endfunction

	// little-endian word from count bytes of the block starting at base
	function automatic logic [63:0] gather_word(input int unsigned base, input int unsigned count);
		logic [63:0] w;
		w = '0;
		for (int unsigned i = 0; i < count; i++)
			w = w | (64'(blk[4'(base + i)]) << (8 * i));
		return w;
	endfunction

	task automatic clear_hash_state();
		lane_a = '0;
		lane_b = '0;
		fill = '0;
		msg_len = '0;
		for (int i = 0; i < 16; i++)
			blk[i] = 8'h00;
	endtask

	task automatic hash_beat(input logic act, input logic [7:0] b);
		logic [63:0] h1;
		logic [63:0] h2;
		int unsigned n;
		digest_t d;
		if (act == ACT_ABSORB) begin
			blk[fill] = b;
			msg_len = msg_len + 64'd1;
			if (fill == 4'd15) begin
				// full block: body round on both lanes
				lane_a = lane_a ^ scr_a(gather_word(0, 8));
				lane_a = rot64(lane_a, 27) + lane_b;
				lane_a = lane_a * 64'd5 + LANE_A_ADD;
				lane_b = lane_b ^ scr_b(gather_word(8, 8));
				lane_b = rot64(lane_b, 31) + lane_a;
				lane_b = lane_b * 64'd5 + LANE_B_ADD;
				fill = '0;
			end else begin
				fill = fill + 4'd1;
			end
		end else begin
			// tail, length and avalanche
			n = {28'd0, fill};
			h1 = lane_a;
			h2 = lane_b;
			if (n > 8)
				h2 = h2 ^ scr_b(gather_word(8, n - 8));
			if (n > 0)
				h1 = h1 ^ scr_a(gather_word(0, (n > 8) ? 8 : n));
			h1 = h1 ^ msg_len;
			h2 = h2 ^ msg_len;
			h1 = h1 + h2;
			h2 = h2 + h1;
			h1 = fold64(h1);
			h2 = fold64(h2);
			h1 = h1 + h2;
			h2 = h2 + h1;
			d.hash_low = h1;
			d.hash_high = h2;
			digest_q.push_back(d);
			clear_hash_state();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp);
		$display("ERROR @%0t: %s: got %h, expected %h", $realtime, what, got, exp);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_beat(input logic act, input logic [7:0] b);
		hash_beat_t t;
		t.action = act;
		t.data_byte = b;
		beat_q.push_back(t);
	endtask

	task automatic add_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			push_beat(ACT_ABSORB, 8'($urandom_range(255)));
		push_beat(ACT_FINISH, 8'($urandom_range(255)));
	endtask

	task automatic add_phase();
		int unsigned added;
		int unsigned len;
		int unsigned pick;
		added = 0;
		while (added < PHASE_BEATS) begin
			pick = $urandom_range(9);
			if (pick < 6)
				len = $urandom_range(40);
			else if (pick < 8)
				len = 16 * $urandom_range(1, 3) - 1 + $urandom_range(2);
			else
				len = $urandom_range(41, 160);
			add_message(len);
			added += len + 1;
		end
	endtask

	// sender stays quiet until every digest is back
	task automatic wait_for_drain();
		do
			@(posedge clk);
		while (beat_q.size() != 0 || s_axis_tvalid || digest_q.size() != 0);
	endtask

	initial begin
		send_idle_pct = 20;
		recv_idle_pct = 52;

		// empty message, data ignored on finish
		push_beat(ACT_FINISH, 8'h00);
		push_beat(ACT_FINISH, 8'hff);
		// single-byte messages at the byte extremes
		push_beat(ACT_ABSORB, 8'h00);
		push_beat(ACT_FINISH, 8'h55);
		push_beat(ACT_ABSORB, 8'hff);
		push_beat(ACT_FINISH, 8'haa);
		// exactly one block, no tail
		for (int i = 0; i < 16; i++)
			push_beat(ACT_ABSORB, (i % 3 == 0) ? 8'hff : ((i % 3 == 1) ? 8'h00 : 8'h5a));
		push_beat(ACT_FINISH, 8'h00);
		add_phase();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait_for_drain();

		send_idle_pct = 52;
		recv_idle_pct = 20;
		add_phase();
		wait_for_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_phase();
		wait_for_drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("murmur3_x64_128_stream test passed");
		else
			$display("murmur3_x64_128_stream test failed");
		$finish;
	end

	initial begin
		#TIMEOUT_NS;
		$display("TIMEOUT at %0t", $realtime);
		$display("murmur3_x64_128_stream test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tuser <= ACT_ABSORB;
			beats_in <= 0;
			clear_hash_state();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				hash_beat(s_axis_tuser, s_axis_tdata);
				beats_in <= beats_in + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = beat_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_beat.data_byte;
					s_axis_tuser <= next_beat.action;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long receiver hold-off, once, in the last phase
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && beats_in >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Output monitor and checker
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					report_mismatch("digest beat with none expected", m_axis_tdata[63:0], 64'h0);
				end else begin
					want = digest_q.pop_front();
					if (m_axis_tdata[63:0] !== want.hash_low)
						report_mismatch("hash_low", m_axis_tdata[63:0], want.hash_low);
					if (m_axis_tdata[127:64] !== want.hash_high)
						report_mismatch("hash_high", m_axis_tdata[127:64], want.hash_high);
				end
			end
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

endmodule
